// ===== sv/assert_macros.svh =====
// assertion macros for the files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/rmv_pkg.sv =====
// constants and controller/datapath interface types for the running mean and variance block
package rmv_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int COUNT_BITS  = 32;
	localparam int VAR_BITS    = 48;
	localparam int FRAC_BITS   = 16;

	// split of the variance for the two partial products
	localparam int VAR_HALF    = VAR_BITS / 2;
	localparam int PART_BITS   = COUNT_BITS + VAR_HALF;
	// full product (n-2)*var and the common divider dividend
	localparam int PROD_BITS   = COUNT_BITS + VAR_BITS;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	// quotient width and number of radix-2 steps
	localparam int QUO_BITS    = PROD_BITS - COUNT_BITS;
	localparam int DIV_STEPS   = QUO_BITS;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [VAR_BITS-1:0]   VAR_MAX   = {VAR_BITS{1'b1}};

	typedef struct packed {
		logic first;      // first sample: load mean, count one, variance zero
		logic capture;    // later sample: register n, |x-mean| and sign
		logic mul_lo;     // (n-2)*var low half, |d|^2
		logic mul_hi;     // (n-2)*var high half
		logic div_start;  // launch the three dividers
		logic commit;     // update state and load the output register
	} rmv_cmd_t;

	typedef struct packed {
		logic cnt_zero;   // no sample seen yet
		logic div_busy;   // a divider is still iterating
		logic out_full;   // result register holds an item not taken this cycle
	} rmv_stat_t;

endpackage

// ===== sv/running_mean_variance.sv =====
// top level of the running mean and sample variance block
//
// channel  handshake             fields
// in       in_valid / in_ready   sample
// out      out_valid / out_ready mean, variance, count, saturated
//
// The first item after reset only loads mean and count and gives no result.
// Each later item passes through capture, two multiply states, divider launch,
// 48 radix-2 divider steps, a wait state until the dividers are idle, and commit;
// the 48-step dividers make up most of the work.
// A result waits in the output register; the next item is taken meanwhile, and
// commit stalls only if the previous result is still not taken.
// Reset clears count, mean and variance at once; no clearing pass.
`include "assert_macros.svh"

module running_mean_variance import rmv_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] mean,
	output logic [VAR_BITS-1:0]    variance,
	output logic [COUNT_BITS-1:0]  count,
	output logic                   saturated
);

	rmv_cmd_t  cmd;
	rmv_stat_t stat;

	rmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rmv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (sample),
		.mean      (mean),
		.variance  (variance),
		.count     (count),
		.saturated (saturated),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	// checks on controller and datapath cooperation
	`ASSERT_IMPLIES(a_idle_div_quiet, clk, arst_n, in_ready, !stat.div_busy)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.div_start, stat.div_busy)
	`ASSERT_NEXT(a_commit_out, clk, arst_n, cmd.commit, out_valid && (count >= COUNT_BITS'(2)))
	`ASSERT_NEXT(a_taken_clears, clk, arst_n, out_valid && out_ready && !cmd.commit, !out_valid)

endmodule

// ===== sv/rmv_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
module rmv_div import rmv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PROD_BITS-1:0]  dividend,
	input  logic [COUNT_BITS-1:0] divisor,
	output logic                  busy,
	output logic [QUO_BITS-1:0]   quotient
);

	logic                  busy_q;
	logic [STEP_W-1:0]     step_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [QUO_BITS-1:0]   sh_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   trial_sub;
	logic                  fits;

	// partial remainder is always below the divisor, so one extra bit suffices
	assign trial     = {rem_q, sh_q[QUO_BITS-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_BITS-1 -: COUNT_BITS];
			sh_q  <= dividend[QUO_BITS-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			sh_q  <= {sh_q[QUO_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = sh_q;

endmodule

// ===== sv/rmv_dp.sv =====
// datapath: running state, multipliers, three dividers and the result register
module rmv_dp import rmv_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmv_cmd_t               cmd,
	output rmv_stat_t              stat,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic [SAMPLE_BITS-1:0] mean,
	output logic [VAR_BITS-1:0]    variance,
	output logic [COUNT_BITS-1:0]  count,
	output logic                   saturated,
	output logic                   out_valid,
	input  logic                   out_ready
);

	// running state
	logic [COUNT_BITS-1:0]  cnt_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [VAR_BITS-1:0]    var_q;

	// per-item work registers
	logic [COUNT_BITS-1:0]  n_q, nm1_q, nm2_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic                   nsat_q;
	logic [PART_BITS-1:0]   plo_q, phi_q;
	logic [SQ_BITS-1:0]     sq_q;

	// result register
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_mean_q;
	logic [VAR_BITS-1:0]    out_var_q;
	logic [COUNT_BITS-1:0]  out_cnt_q;
	logic                   out_sat_q;

	logic [SAMPLE_BITS:0]   diff, diff_abs;
	logic [COUNT_BITS-1:0]  n_next;
	logic [PROD_BITS-1:0]   prod;
	logic [QUO_BITS-1:0]    t1, t2, qm;
	logic                   busy1, busy2, busy3;
	logic [VAR_BITS:0]      vsum;
	logic                   vovf;
	logic [VAR_BITS-1:0]    var_new;
	logic [SAMPLE_BITS-1:0] qmean;
	logic [SAMPLE_BITS-1:0] mean_new;

	// deviation from the old mean, exact in one extra bit
	assign diff     = {sample[SAMPLE_BITS-1], sample} - {mean_q[SAMPLE_BITS-1], mean_q};
	assign diff_abs = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;

	// count saturates at its maximum
	assign n_next = (cnt_q == COUNT_MAX) ? COUNT_MAX : (cnt_q + 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			n_q    <= n_next;
			nm1_q  <= n_next - 1'b1;
			nm2_q  <= n_next - 2'd2;
			mag_q  <= diff_abs[SAMPLE_BITS-1:0];
			neg_q  <= diff[SAMPLE_BITS];
			nsat_q <= (n_next == COUNT_MAX);
		end
		if (cmd.mul_lo) begin
			plo_q <= PART_BITS'(nm2_q) * PART_BITS'(var_q[VAR_HALF-1:0]);
			sq_q  <= SQ_BITS'(mag_q) * SQ_BITS'(mag_q);
		end
		if (cmd.mul_hi) begin
			phi_q <= PART_BITS'(nm2_q) * PART_BITS'(var_q[VAR_BITS-1:VAR_HALF]);
		end
	end

	// full (n-2)*var from the two partial products
	assign prod = PROD_BITS'(plo_q) + {phi_q, VAR_HALF'(0)};

	// ((n-2)*var)/(n-1)
	rmv_div u_div_var (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod),
		.divisor  (nm1_q),
		.busy     (busy1),
		.quotient (t1)
	);

	// (d^2 >> 16)/n
	rmv_div u_div_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (PROD_BITS'(sq_q >> FRAC_BITS)),
		.divisor  (n_q),
		.busy     (busy2),
		.quotient (t2)
	);

	// |d|/n for the mean step
	rmv_div u_div_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (PROD_BITS'(mag_q)),
		.divisor  (n_q),
		.busy     (busy3),
		.quotient (qm)
	);

	// saturating variance sum and mean step
	assign vsum     = {1'b0, t1} + {1'b0, t2};
	assign vovf     = (vsum >= {1'b0, VAR_MAX});
	assign var_new  = vovf ? VAR_MAX : vsum[VAR_BITS-1:0];
	assign qmean    = qm[SAMPLE_BITS-1:0];
	assign mean_new = neg_q ? (mean_q - qmean) : (mean_q + qmean);

	// running state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			mean_q <= '0;
			var_q  <= '0;
		end else if (cmd.first) begin
			cnt_q  <= COUNT_BITS'(1);
			mean_q <= sample;
			var_q  <= '0;
		end else if (cmd.commit) begin
			cnt_q  <= n_q;
			mean_q <= mean_new;
			var_q  <= var_new;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_mean_q <= mean_new;
			out_var_q  <= var_new;
			out_cnt_q  <= n_q;
			out_sat_q  <= nsat_q | vovf;
		end
	end

	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.div_busy = busy1 | busy2 | busy3;
	assign stat.out_full = out_valid_q & ~out_ready;

	assign out_valid = out_valid_q;
	assign mean      = out_mean_q;
	assign variance  = out_var_q;
	assign count     = out_cnt_q;
	assign saturated = out_sat_q;

endmodule

// ===== sv/rmv_ctrl.sv =====
// controller: sequences capture, multiply, divide and commit for each item after the first
module rmv_ctrl import rmv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rmv_stat_t stat,
	output rmv_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_COMMIT
	} state_t;

	state_t state_q;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.first     = (state_q == ST_IDLE) & in_valid & stat.cnt_zero;
		cmd.capture   = (state_q == ST_IDLE) & in_valid & ~stat.cnt_zero;
		cmd.mul_lo    = (state_q == ST_MUL_LO);
		cmd.mul_hi    = (state_q == ST_MUL_HI);
		cmd.div_start = (state_q == ST_DIV_GO);
		cmd.commit    = (state_q == ST_COMMIT) & ~stat.out_full;
	end

	assign in_ready = (state_q == ST_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !stat.cnt_zero) begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: begin
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (!stat.div_busy) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (!stat.out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
